// ===== rtl/image_convolution_3x3_macros.svh =====
`ifndef IMAGE_CONVOLUTION_3X3_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ICC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ICC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icc_pkg.sv =====
package icc_pkg;

  localparam int unsigned MAX_WIDTH_DEF      = 1024;
  localparam int unsigned COEF_FRAC_BITS_DEF = 12;
  localparam int unsigned KERNEL_SIZE        = 3;
  localparam int unsigned TAPS               = KERNEL_SIZE * KERNEL_SIZE;
  localparam int unsigned PIX_W              = 8;
  localparam int unsigned CHANNELS           = 3;
  localparam int unsigned PX_W               = PIX_W * CHANNELS;
  localparam int unsigned COEF_W             = 16;
  localparam int unsigned DIM_W              = 11;
  localparam int unsigned DIV_W              = 16;
  localparam int unsigned KROW_W             = COEF_W * KERNEL_SIZE;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 48;

  localparam logic [DIM_W-1:0]  LINE_WIDTH_RST   = 11'd640;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
  localparam logic [DIV_W-1:0]  DIVISOR_RST      = 16'd1;
  localparam logic [KROW_W-1:0] KROW_TOP_RST     = 48'd0;
  localparam logic [KROW_W-1:0] KROW_MID_RST     = 48'd4096;
  localparam logic [KROW_W-1:0] KROW_BOT_RST     = 48'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_COLOR_MODE    = 3'd2,
    REG_DIVISOR       = 3'd3,
    REG_KERNEL_TOP    = 3'd4,
    REG_KERNEL_MIDDLE = 3'd5,
    REG_KERNEL_BOTTOM = 3'd6
  } cfg_reg_e;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic done;
    pix_t res;
  } lane_out_t;

endpackage

// ===== rtl/icc_pix_if.sv =====
interface icc_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [icc_pkg::PIX_W-1:0] chan_zero;
  logic [icc_pkg::PIX_W-1:0] chan_one;
  logic [icc_pkg::PIX_W-1:0] chan_two;

  modport source (output valid, opcode, chan_zero, chan_one, chan_two, input ready);
  modport sink (input valid, opcode, chan_zero, chan_one, chan_two, output ready);
endinterface

// ===== rtl/icc_res_if.sv =====
interface icc_res_if;
  logic                     valid;
  logic                     ready;
  logic [icc_pkg::PIX_W-1:0] res_zero;
  logic [icc_pkg::PIX_W-1:0] res_one;
  logic [icc_pkg::PIX_W-1:0] res_two;
  logic                     row_end;
  logic                     frame_end;
  logic                     run_last;

  modport source (output valid, res_zero, res_one, res_two, row_end, frame_end, run_last,
                  input ready);
  modport sink (input valid, res_zero, res_one, res_two, row_end, frame_end, run_last,
                output ready);
endinterface

// ===== rtl/icc_cfg_if.sv =====
interface icc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [icc_pkg::CFG_IDX_W-1:0]  index;
  logic [icc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/icc_line_store.sv =====
module icc_line_store #(
  parameter int unsigned DEPTH = icc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WIDTH = 2 * icc_pkg::PX_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/icc_lane.sv =====
module icc_lane #(
  parameter int unsigned COEF_FRAC_BITS = icc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  icc_pkg::pix_t  [icc_pkg::TAPS-1:0]     px_i,
  input  icc_pkg::coef_t [icc_pkg::TAPS-1:0]     coef_i,
  input  logic [icc_pkg::DIV_W-1:0]              divisor_i,
  output icc_pkg::lane_out_t                     result_o
);

  localparam int unsigned PROD_W = icc_pkg::PIX_W + 1 + icc_pkg::COEF_W;
  localparam int unsigned SUM_W  = PROD_W + $clog2(icc_pkg::TAPS);
  localparam int unsigned DEN_W  = icc_pkg::DIV_W + COEF_FRAC_BITS;
  localparam int unsigned QB     = icc_pkg::PIX_W + 1;
  localparam int unsigned CMP_W  = ((SUM_W > DEN_W + QB - 1) ? SUM_W : DEN_W + QB - 1) + 1;
  localparam int unsigned LAST   = QB + 1;
  localparam int unsigned STEP_W = $clog2(LAST + 1);

  logic signed [PROD_W-1:0] prod_q [icc_pkg::TAPS];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]         rem_q;
  logic [QB-1:0]            quo_q;
  logic [DEN_W-1:0]         den_q;
  logic [STEP_W-1:0]        step_q;
  logic                     busy_q, done_q;
  logic [CMP_W-1:0]         den_sh, rem_ext;
  logic [STEP_W-1:0]        shift;
  logic [SUM_W-1:0]         mag;

  always_comb begin
    sum_d = '0;
    for (int t = 0; t < icc_pkg::TAPS; t++) begin
      sum_d = sum_d + SUM_W'(prod_q[t]);
    end
  end

  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign shift   = STEP_W'(LAST) - step_q;
  assign den_sh  = CMP_W'(den_q) << shift;
  assign rem_ext = CMP_W'(rem_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int t = 0; t < icc_pkg::TAPS; t++) begin
        prod_q[t] <= PROD_W'($signed({1'b0, px_i[t]})) * PROD_W'(coef_i[t]);
      end
      den_q <= {((divisor_i == '0) ? icc_pkg::DIV_W'(1) : divisor_i),
                COEF_FRAC_BITS'(0)};
    end
    if (busy_q) begin
      if (step_q == '0) begin
        sum_q <= sum_d;
      end else if (step_q == STEP_W'(1)) begin
        rem_q <= mag;
        quo_q <= '0;
      end else if (rem_ext >= den_sh) begin
        rem_q        <= SUM_W'(rem_ext - den_sh);
        quo_q[shift] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(LAST));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(LAST)) begin
          busy_q <= 1'b0;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  assign result_o.done = done_q;
  assign result_o.res  = quo_q[QB-1] ? '1 : quo_q[QB-2:0];

endmodule

// ===== rtl/image_convolution_3x3.sv =====
// An item with no result passes through the update state and back to idle.
// Each result passes launch, products, sum, magnitude, 9 divide steps and push,
// and an item yields none, one or two results; each channel has its own divider.
// Throughput: one item at a time; input is not taken while an item is at work.
// Reset: control and config registers return to their defaults, then a clearing
// pass over all MAX_WIDTH words zeroes the line store; no input is taken until it ends.
module image_convolution_3x3 #(
  parameter int unsigned MAX_WIDTH      = icc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = icc_pkg::COEF_FRAC_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  icc_pix_if.sink     pix_in,
  icc_res_if.source   res_out,
  icc_cfg_if.sink     cfg
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned LW  = (icc_pkg::DIM_W > AW + 1) ? icc_pkg::DIM_W : AW + 1;
  localparam int unsigned K   = icc_pkg::KERNEL_SIZE;
  localparam int unsigned PXW = icc_pkg::PX_W;
  localparam int unsigned PW  = icc_pkg::PIX_W;
  localparam int unsigned DW  = icc_pkg::DIM_W;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_CALC   = 6'b010000,
    ST_PUSH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DW-1:0]             line_width_q, frame_height_q;
  logic                      color_mode_q;
  logic [icc_pkg::DIV_W-1:0] divisor_q;
  logic [icc_pkg::KROW_W-1:0] krow_q [K];

  logic [AW-1:0] col_q, clr_q, c_q, wl;
  logic [DW-1:0] row_q, ir_q, h_eff;
  logic [PXW-1:0] pix_q, pix_d;
  logic last_q, flush_q, emit2_q, second_q;
  logic [PXW-1:0] win_q [K][K];

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [2*PXW-1:0] mem_wdata, mem_rdata;
  logic [PXW-1:0]  top_px, mid_px;

  logic                 out_valid_q;
  icc_pkg::pix_t [icc_pkg::CHANNELS-1:0] out_res_q;
  logic                 out_row_q, out_frame_q, out_last_q;

  logic in_acc, push_ok, lanes_done, lane_start;
  logic [1:0] sel_col [K];
  logic       sel_en  [K];

  icc_pkg::pix_t  [icc_pkg::TAPS-1:0] lane_px [icc_pkg::CHANNELS];
  icc_pkg::coef_t [icc_pkg::TAPS-1:0] coef;
  icc_pkg::lane_out_t lane_res [icc_pkg::CHANNELS];
  logic [icc_pkg::CHANNELS-1:0] lane_done;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = (state_q == ST_IDLE);
  assign in_acc       = pix_in.valid && pix_in.ready;
  assign push_ok      = !out_valid_q || res_out.ready;

  always_comb begin
    if (line_width_q == '0) begin
      wl = '0;
    end else if (LW'(line_width_q) > LW'(MAX_WIDTH)) begin
      wl = AW'(MAX_WIDTH - 1);
    end else begin
      wl = AW'(line_width_q - DW'(1));
    end
    h_eff = (frame_height_q == '0) ? DW'(1) : frame_height_q;
  end

  always_comb begin
    if (pix_in.opcode || (row_q >= h_eff)) begin
      pix_d = '0;
    end else if (color_mode_q) begin
      pix_d = {pix_in.chan_two, pix_in.chan_one, pix_in.chan_zero};
    end else begin
      pix_d = {(PXW - PW)'(0), pix_in.chan_zero};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= icc_pkg::LINE_WIDTH_RST;
      frame_height_q <= icc_pkg::FRAME_HEIGHT_RST;
      color_mode_q   <= 1'b0;
      divisor_q      <= icc_pkg::DIVISOR_RST;
      krow_q[0]      <= icc_pkg::KROW_TOP_RST;
      krow_q[1]      <= icc_pkg::KROW_MID_RST;
      krow_q[2]      <= icc_pkg::KROW_BOT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (icc_pkg::cfg_reg_e'(cfg.index))
        icc_pkg::REG_LINE_WIDTH:    line_width_q   <= cfg.data[DW-1:0];
        icc_pkg::REG_FRAME_HEIGHT:  frame_height_q <= cfg.data[DW-1:0];
        icc_pkg::REG_COLOR_MODE:    color_mode_q   <= cfg.data[0];
        icc_pkg::REG_DIVISOR:       divisor_q      <= cfg.data[icc_pkg::DIV_W-1:0];
        icc_pkg::REG_KERNEL_TOP:    krow_q[0]      <= cfg.data[icc_pkg::KROW_W-1:0];
        icc_pkg::REG_KERNEL_MIDDLE: krow_q[1]      <= cfg.data[icc_pkg::KROW_W-1:0];
        icc_pkg::REG_KERNEL_BOTTOM: krow_q[2]      <= cfg.data[icc_pkg::KROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign top_px    = (ir_q >= DW'(2)) ? mem_rdata[2*PXW-1:PXW] : '0;
  assign mid_px    = (ir_q >= DW'(1)) ? mem_rdata[PXW-1:0] : '0;
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : c_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {mem_rdata[PXW-1:0], pix_q};

  icc_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PXW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == AW'(MAX_WIDTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = ST_UPDATE;
      ST_UPDATE: begin
        if ((ir_q != '0) && ((c_q != '0) || last_q)) begin
          state_d = ST_LAUNCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LAUNCH: state_d = ST_CALC;
      ST_CALC:   if (lanes_done) state_d = ST_PUSH;
      ST_PUSH: begin
        if (push_ok) begin
          state_d = (!second_q && emit2_q) ? ST_LAUNCH : ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      emit2_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_UPDATE) begin
        emit2_q  <= (ir_q != '0) && last_q;
        second_q <= (c_q == '0);
        if (last_q) begin
          col_q <= '0;
          row_q <= flush_q ? '0 : ir_q + DW'(1);
        end else begin
          col_q <= c_q + AW'(1);
        end
      end
      if ((state_q == ST_PUSH) && push_ok && !second_q && emit2_q) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q   <= pix_d;
      c_q     <= col_q;
      ir_q    <= row_q;
      last_q  <= (col_q >= wl);
      flush_q <= (row_q >= h_eff);
    end
    if (state_q == ST_UPDATE) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K - 1; n++) begin
          win_q[m][n] <= win_q[m][n+1];
        end
      end
      win_q[0][K-1] <= top_px;
      win_q[1][K-1] <= mid_px;
      win_q[2][K-1] <= pix_q;
    end
  end

  always_comb begin
    for (int n = 0; n < K; n++) begin
      if (second_q) begin
        sel_col[n] = 2'(n + 1);
        sel_en[n]  = (n == 0) ? (c_q != '0) : (n < K - 1);
      end else begin
        sel_col[n] = 2'(n);
        sel_en[n]  = (n == 0) ? (c_q >= AW'(2)) : 1'b1;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < icc_pkg::CHANNELS; ch++) begin
      for (int m = 0; m < K; m++) begin
        for (int n = 0; n < K; n++) begin
          lane_px[ch][m*K+n] = sel_en[n] ? win_q[m][sel_col[n]][ch*PW +: PW] : '0;
        end
      end
    end
    for (int m = 0; m < K; m++) begin
      for (int n = 0; n < K; n++) begin
        coef[m*K+n] = krow_q[K-1-m][icc_pkg::COEF_W*(K-1-n) +: icc_pkg::COEF_W];
      end
    end
  end

  assign lane_start = (state_q == ST_LAUNCH);

  for (genvar ch = 0; ch < icc_pkg::CHANNELS; ch++) begin : g_lane
    icc_lane #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (lane_start),
      .px_i      (lane_px[ch]),
      .coef_i    (coef),
      .divisor_i (divisor_q),
      .result_o  (lane_res[ch])
    );
    assign lane_done[ch] = lane_res[ch].done;
  end

  assign lanes_done = &lane_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_PUSH) && push_ok) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PUSH) && push_ok) begin
      out_res_q[0] <= lane_res[0].res;
      out_res_q[1] <= color_mode_q ? lane_res[1].res : '0;
      out_res_q[2] <= color_mode_q ? lane_res[2].res : '0;
      out_row_q    <= second_q;
      out_frame_q  <= second_q && flush_q;
      out_last_q   <= second_q || !emit2_q;
    end
  end

  assign res_out.valid     = out_valid_q;
  assign res_out.res_zero  = out_res_q[0];
  assign res_out.res_one   = out_res_q[1];
  assign res_out.res_two   = out_res_q[2];
  assign res_out.row_end   = out_row_q;
  assign res_out.frame_end = out_frame_q;
  assign res_out.run_last  = out_last_q;

endmodule

// ===== rtl/icc_checker.sv =====
`include "image_convolution_3x3_macros.svh"

module icc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [icc_pkg::PIX_W-1:0] out_res_zero,
  input logic                      out_row_end,
  input logic                      out_frame_end,
  input logic                      out_run_last
);

  `ICC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_res_zero), "stalled result changed")
  `ICC_ASSERT_NOW(a_frame_row, out_valid && out_frame_end, out_row_end && out_run_last, "frame end off a row end")
  `ICC_ASSERT_NOW(a_row_last, out_valid && out_row_end, out_run_last, "row end not last of its transaction")
  `ICC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while an item is at work")

endmodule

bind image_convolution_3x3 icc_checker u_icc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (res_out.valid),
  .out_ready     (res_out.ready),
  .out_res_zero  (res_out.res_zero),
  .out_row_end   (res_out.row_end),
  .out_frame_end (res_out.frame_end),
  .out_run_last  (res_out.run_last)
);
